FILE: hdl/modular_inverse_unit_macros.svh
// assertion macros for the modular inverse unit
// expects clk and rst_n in the scope where a macro is used
`ifndef MODULAR_INVERSE_UNIT_MACROS_SVH
`define MODULAR_INVERSE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MIU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular inverse unit: implication check failed");

// next-cycle implication, checked outside reset
`define MIU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular inverse unit: next-cycle check failed");

`endif

FILE: hdl/miu_pkg.sv
// shared constants and sequencer state type of the modular inverse unit
// no dependencies
package miu_pkg;

    localparam int DATA_BITS = 16;
    localparam logic [DATA_BITS-1:0] MODULUS_RESET = 16'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EUCLID,
        ST_UPDATE,
        ST_FINISH
    } miu_state_t;

endpackage

FILE: hdl/modular_inverse_unit.sv
// Modular inverse by extended Euclid with one shared bit-serial divider.
// Channels: in_valid/in_ready carry value; out_valid/out_ready carry inverse,
// invertible and common_divisor. modulus_we writes the modulus register.
// Depends on miu_pkg and modular_inverse_unit_macros.svh.
//
// One transaction at a time; in_ready is high only while the sequencer idles.
// The value is first reduced mod m by the restoring divider (W = WORD_BITS
// is its width). Each Euclid step is one division, during which q*t1 mod m
// is formed from the quotient bits, followed by an update state for the
// remainders and coefficients; a run has k Euclid steps, k at most about
// 1.44*W. A zero modulus or a value that reduces to zero goes straight to
// the finish state. in_ready returns once the finish state hands the result
// to the output register, so a new value is not taken before the last one
// is through.
// The result sits in an output register, so the next value is taken while it
// waits; if out_ready stays low a finished result is held until the slot
// frees. Reset empties the output and sets the modulus to 256.
module modular_inverse_unit
    import miu_pkg::*;
#(
    parameter int WORD_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 modulus_we,
    input  logic [DATA_BITS-1:0] modulus,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DATA_BITS-1:0] value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_BITS-1:0] inverse,
    output logic                 invertible,
    output logic [DATA_BITS-1:0] common_divisor
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W);
    localparam int XW = (W > DATA_BITS) ? W : DATA_BITS;

    miu_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DATA_BITS-1:0] modulus_reg;
    logic out_valid_reg, out_valid_next;

    logic [W-1:0] m_reg, m_next;
    logic [W-1:0] dvd_reg, dvd_next;
    logic [W-1:0] dsr_reg, dsr_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] p_reg, p_next;
    logic [W-1:0] t0_reg, t0_next;
    logic [W-1:0] t1_reg, t1_next;
    logic [W-1:0] res_g_reg, res_g_next;
    logic [W-1:0] res_inv_reg, res_inv_next;
    logic         res_ok_reg, res_ok_next;
    logic [DATA_BITS-1:0] inverse_reg, inverse_next;
    logic [DATA_BITS-1:0] gcd_reg, gcd_next;
    logic                 ok_reg, ok_next;

    logic [XW-1:0] mod_x, val_x, g_x, inv_x;
    logic [W-1:0]  mod_w, val_w;

    // shared datapath: one restoring-divider step plus modular q*t1 accumulation
    logic [W:0]   div_shift, div_diff, m_ext;
    logic         div_ge, div_last;
    logic [W-1:0] rem_step;
    logic [W:0]   p_dbl, p_dbl_sub, p_dbl_red, p_sum, p_sum_sub;
    logic [W-1:0] p_step;
    logic [W:0]   t_diff, t_wrap;
    logic [W-1:0] t_new;

    assign mod_x = XW'(modulus_reg);
    assign val_x = XW'(value);
    assign mod_w = mod_x[W-1:0];
    assign val_w = val_x[W-1:0];
    assign g_x   = XW'(res_g_reg);
    assign inv_x = XW'(res_inv_reg);

    assign m_ext     = {1'b0, m_reg};
    assign div_shift = {rem_reg, dvd_reg[W-1]};
    assign div_ge    = div_shift >= {1'b0, dsr_reg};
    assign div_diff  = div_shift - {1'b0, dsr_reg};
    assign rem_step  = div_ge ? div_diff[W-1:0] : div_shift[W-1:0];
    assign div_last  = cnt_reg == CW'(W - 1);

    // p tracks (quotient so far * t1) mod m, msb first
    assign p_dbl     = {p_reg, 1'b0};
    assign p_dbl_sub = p_dbl - m_ext;
    assign p_dbl_red = (p_dbl >= m_ext) ? p_dbl_sub : p_dbl;
    assign p_sum     = p_dbl_red + (div_ge ? {1'b0, t1_reg} : '0);
    assign p_sum_sub = p_sum - m_ext;
    assign p_step    = (p_sum >= m_ext) ? p_sum_sub[W-1:0] : p_sum[W-1:0];

    assign t_diff = {1'b0, t0_reg} - {1'b0, p_reg};
    assign t_wrap = {1'b0, t0_reg} + m_ext - {1'b0, p_reg};
    assign t_new  = (t0_reg >= p_reg) ? t_diff[W-1:0] : t_wrap[W-1:0];

    assign in_ready       = state_reg == ST_IDLE;
    assign out_valid      = out_valid_reg;
    assign inverse        = inverse_reg;
    assign invertible     = ok_reg;
    assign common_divisor = gcd_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        m_next         = m_reg;
        dvd_next       = dvd_reg;
        dsr_next       = dsr_reg;
        rem_next       = rem_reg;
        p_next         = p_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        res_g_next     = res_g_reg;
        res_inv_next   = res_inv_reg;
        res_ok_next    = res_ok_reg;
        inverse_next   = inverse_reg;
        gcd_next       = gcd_reg;
        ok_next        = ok_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    m_next = mod_w;
                    if (mod_w == '0)
                    begin
                        res_g_next   = val_w;
                        res_inv_next = '0;
                        res_ok_next  = 1'b0;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        dvd_next   = val_w;
                        dsr_next   = mod_w;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                rem_next = rem_step;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + CW'(1);
                if (div_last)
                begin
                    cnt_next = '0;
                    if (rem_step == '0)
                    begin
                        res_g_next   = m_reg;
                        res_inv_next = '0;
                        res_ok_next  = 1'b0;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        dvd_next   = m_reg;
                        dsr_next   = rem_step;
                        rem_next   = '0;
                        p_next     = '0;
                        t0_next    = '0;
                        t1_next    = W'(1);
                        state_next = ST_EUCLID;
                    end
                end
            end
            ST_EUCLID:
            begin
                rem_next = rem_step;
                dvd_next = dvd_reg << 1;
                p_next   = p_step;
                cnt_next = cnt_reg + CW'(1);
                if (div_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                t0_next = t1_reg;
                t1_next = t_new;
                if (rem_reg == '0)
                begin
                    res_g_next   = dsr_reg;
                    res_ok_next  = dsr_reg == W'(1);
                    res_inv_next = (dsr_reg == W'(1)) ? t1_reg : '0;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    dvd_next   = dsr_reg;
                    dsr_next   = rem_reg;
                    rem_next   = '0;
                    p_next     = '0;
                    state_next = ST_EUCLID;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    inverse_next   = inv_x[DATA_BITS-1:0];
                    gcd_next       = g_x[DATA_BITS-1:0];
                    ok_next        = res_ok_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            modulus_reg   <= MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (modulus_we)
            begin
                modulus_reg <= modulus;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg       <= m_next;
        dvd_reg     <= dvd_next;
        dsr_reg     <= dsr_next;
        rem_reg     <= rem_next;
        p_reg       <= p_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        res_g_reg   <= res_g_next;
        res_inv_reg <= res_inv_next;
        res_ok_reg  <= res_ok_next;
        inverse_reg <= inverse_next;
        gcd_reg     <= gcd_next;
        ok_reg      <= ok_next;
    end

`include "modular_inverse_unit_macros.svh"

    `MIU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `MIU_ASSERT_IMP(a_ok_means_unit_gcd, out_valid && invertible, common_divisor == DATA_BITS'(1))
    `MIU_ASSERT_IMP(a_zero_when_not_ok, out_valid && !invertible, inverse == '0)
    `MIU_ASSERT_IMP(a_divisor_nonzero, state_reg == ST_EUCLID, dsr_reg != '0)

endmodule
